>>> design/tksh_pkg.sv
// ----------------------------------------------------------------------------
// tksh_pkg
// Shared types and constants of the table-keyed string hash.
// ----------------------------------------------------------------------------
package tksh_pkg;

    // Field widths of one input word and one result word.
    localparam int KEY_BYTE_W  = 8;
    localparam int TABLE_ROW_W = 3;
    localparam int HASH_W      = 32;

    // Entries in one row of the seed table.
    localparam int ROW_SIZE    = 256;

    // Congruential generator: s = (s * 125 + 3) mod 0x2AAAAB.
    // Three times the modulus is 2^23 + 1, so the product folds at bit 23.
    localparam int LCG_W       = 22;
    localparam int LCG_PROD_W  = 29;
    localparam int LCG_FOLD_SH = 23;
    localparam int LCG_HALF_W  = 16;
    localparam logic [LCG_W-1:0] LCG_START = 22'h100001;
    localparam logic [6:0]       LCG_MUL   = 7'd125;
    localparam logic [1:0]       LCG_ADD   = 2'd3;
    localparam logic [LCG_W-1:0] LCG_MOD   = 22'h2AAAAB;
    localparam logic [LCG_FOLD_SH:0] LCG_MOD3 = 24'h800001;

    // Seed values at the start of a key.
    localparam logic [HASH_W-1:0] SEED1_INIT = 32'h7FED7FED;
    localparam logic [HASH_W-1:0] SEED2_INIT = 32'hEEEEEEEE;
    localparam logic [1:0]        SEED2_ADD  = 2'd3;

    // ASCII lower-case range and the offset to upper case.
    localparam logic [KEY_BYTE_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [KEY_BYTE_W-1:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [KEY_BYTE_W-1:0] CASE_OFFSET  = 8'h20;

    typedef logic [HASH_W-1:0]     hash_t;
    typedef logic [KEY_BYTE_W-1:0] key_byte_t;

endpackage

>>> design/tksh_if.sv
// ----------------------------------------------------------------------------
// tksh_if
// Valid/ready channels of the table-keyed string hash: key words in,
// hash words out.
// ----------------------------------------------------------------------------
interface tksh_in_if import tksh_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic                   key_start;
    logic [TABLE_ROW_W-1:0] table_row;
    logic [KEY_BYTE_W-1:0]  key_byte;

    modport source (output valid, output key_start, output table_row,
                    output key_byte, input ready);
    modport sink   (input valid, input key_start, input table_row,
                    input key_byte, output ready);
endinterface

interface tksh_out_if import tksh_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [HASH_W-1:0] hash_value;

    modport source (output valid, output hash_value, input ready);
    modport sink   (input valid, input hash_value, output ready);
endinterface

>>> design/tksh_fill.sv
// ----------------------------------------------------------------------------
// tksh_fill
// Seed table generator. Steps the congruential sequence through a multiply,
// a fold at bit 23 against 2^23 + 1, then a final compare and subtract, and
// writes one table word for every two steps, column by column.
// ----------------------------------------------------------------------------
module tksh_fill import tksh_pkg::*;
#(
    parameter int TABLE_ROWS = 5
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    output logic                                    wr_en,
    output logic [$clog2(TABLE_ROWS*ROW_SIZE)-1:0]  wr_addr,
    output logic [HASH_W-1:0]                       wr_data,
    output logic                                    done
);

    localparam int ADDR_W = $clog2(TABLE_ROWS*ROW_SIZE);
    localparam int ROW_W  = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;
    localparam int FOLD_W = LCG_FOLD_SH + 1;
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(TABLE_ROWS - 1);
    localparam logic [7:0]       LAST_COL = 8'(ROW_SIZE - 1);
    localparam logic [FOLD_W-1:0] MOD_X1  = FOLD_W'(LCG_MOD);
    localparam logic [FOLD_W-1:0] MOD_X2  = {MOD_X1[FOLD_W-2:0], 1'b0};

    // Sequencer states.
    localparam logic [1:0] ST_MUL  = 2'd0;
    localparam logic [1:0] ST_FOLD = 2'd1;
    localparam logic [1:0] ST_SUB  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [LCG_W-1:0]      lcg_reg, lcg_next;
    logic [LCG_PROD_W-1:0] rem_reg, rem_next;
    logic                  phase_reg, phase_next;
    logic [LCG_HALF_W-1:0] hi_reg, hi_next;
    logic [ROW_W-1:0]      row_reg, row_next;
    logic [7:0]            col_reg, col_next;

    logic [FOLD_W-1:0]     fold_diff;
    logic [FOLD_W-1:0]     fold_wrap;
    logic [FOLD_W-1:0]     sub_in;
    logic [FOLD_W-1:0]     sub_full;
    logic [LCG_W-1:0]      lcg_reduced;

    // Fold the product: 2^23 is congruent to -1 modulo 2^23 + 1.
    assign fold_diff = {1'b0, rem_reg[LCG_FOLD_SH-1:0]}
                       - FOLD_W'(rem_reg[LCG_PROD_W-1:LCG_FOLD_SH]);
    assign fold_wrap = fold_diff[FOLD_W-1] ? (fold_diff + LCG_MOD3) : fold_diff;

    // The folded value is below three moduli; take off at most two.
    assign sub_in = rem_reg[FOLD_W-1:0];

    always_comb
    begin
        if (sub_in >= MOD_X2)
        begin
            sub_full = sub_in - MOD_X2;
        end
        else if (sub_in >= MOD_X1)
        begin
            sub_full = sub_in - MOD_X1;
        end
        else
        begin
            sub_full = sub_in;
        end
    end

    assign lcg_reduced = sub_full[LCG_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        lcg_next   = lcg_reg;
        rem_next   = rem_reg;
        phase_next = phase_reg;
        hi_next    = hi_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        wr_en      = 1'b0;
        case (state_reg)
            ST_MUL:
            begin
                rem_next   = LCG_PROD_W'(lcg_reg) * LCG_PROD_W'(LCG_MUL)
                             + LCG_PROD_W'(LCG_ADD);
                state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                rem_next   = LCG_PROD_W'(fold_wrap);
                state_next = ST_SUB;
            end
            ST_SUB:
            begin
                lcg_next   = lcg_reduced;
                state_next = ST_MUL;
                if (!phase_reg)
                begin
                    // First step of a word gives its upper half.
                    hi_next    = lcg_reduced[LCG_HALF_W-1:0];
                    phase_next = 1'b1;
                end
                else
                begin
                    // Second step completes the word; move to next row, or to the next column after the last row.
                    wr_en      = 1'b1;
                    phase_next = 1'b0;
                    if (row_reg == LAST_ROW)
                    begin
                        row_next = '0;
                        col_next = col_reg + 1'b1;
                        if (col_reg == LAST_COL)
                        begin
                            state_next = ST_DONE;
                        end
                    end
                    else
                    begin
                        row_next = row_reg + 1'b1;
                    end
                end
            end
            ST_DONE:
            begin
                state_next = ST_DONE;
            end
            default:
            begin
                state_next = ST_MUL;
            end
        endcase
    end

    assign wr_addr = ADDR_W'({row_reg, col_reg});
    assign wr_data = {hi_reg, lcg_reduced[LCG_HALF_W-1:0]};
    assign done    = (state_reg == ST_DONE);

    // Sequencer registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_MUL;
            lcg_reg   <= LCG_START;
            phase_reg <= 1'b0;
            row_reg   <= '0;
            col_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            lcg_reg   <= lcg_next;
            phase_reg <= phase_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        hi_reg  <= hi_next;
    end

`ifndef SYNTH
    // Once the table is full it stays full and is never written again.
    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> done)
        else $error("fill done dropped");
    a_no_write_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !wr_en)
        else $error("table written after fill completed");
    // A word is written only on the second generator step.
    a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (phase_reg && state_reg == ST_SUB))
        else $error("table write outside the second step");
`endif

endmodule

>>> design/tksh_core.sv
// ----------------------------------------------------------------------------
// tksh_core
// Seed table memory and hash datapath. A key word reads its table entry into
// a register in the accept cycle; the second stage then folds the entry into
// the two seeds and loads the result into the output register once it is free.
// ----------------------------------------------------------------------------
module tksh_core import tksh_pkg::*;
#(
    parameter int TABLE_ROWS = 5
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    wr_en,
    input  logic [$clog2(TABLE_ROWS*ROW_SIZE)-1:0]  wr_addr,
    input  logic [HASH_W-1:0]                       wr_data,
    input  logic                                    fill_done,
    tksh_in_if.sink                                 key_in,
    tksh_out_if.source                              hash_out
);

    localparam int DEPTH  = TABLE_ROWS * ROW_SIZE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int ROW_W  = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;
    localparam logic [TABLE_ROW_W:0] ROW_LIMIT = (TABLE_ROW_W+1)'(TABLE_ROWS);

    logic [HASH_W-1:0] table_mem [0:DEPTH-1];
    logic [HASH_W-1:0] rd_data_reg;

    logic              s1_valid_reg, s1_valid_next;
    logic              s1_start_reg;
    logic              s1_in_range_reg;
    key_byte_t         s1_char_reg;
    hash_t             seed1_reg, seed1_next;
    hash_t             seed2_reg, seed2_next;
    logic              out_valid_reg, out_valid_next;
    hash_t             out_hash_reg;

    logic              out_free;
    logic              s1_fire;
    logic              accept;
    key_byte_t         char_up;
    logic              in_range;
    logic [ADDR_W-1:0] rd_addr;
    hash_t             seed1_cur;
    hash_t             seed2_cur;
    hash_t             table_word;

    // Handshake: the output register frees when empty or being taken.
    assign out_free      = !out_valid_reg || hash_out.ready;
    assign s1_fire       = s1_valid_reg && out_free;
    assign key_in.ready  = fill_done && (!s1_valid_reg || out_free);
    assign accept        = key_in.valid && key_in.ready;

    // Upper-case the byte and form the table address.
    always_comb
    begin
        char_up = key_in.key_byte;
        if (key_in.key_byte inside {[CHAR_LOWER_A:CHAR_LOWER_Z]})
        begin
            char_up = key_in.key_byte - CASE_OFFSET;
        end
    end

    assign in_range = ({1'b0, key_in.table_row} < ROW_LIMIT);
    assign rd_addr  = in_range ? ADDR_W'({ROW_W'(key_in.table_row), char_up}) : '0;

    // Seed table: one write port for the fill, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_data_reg <= table_mem[rd_addr];
        end
    end

    // Seed update for the word in the second stage.
    assign seed1_cur  = s1_start_reg ? SEED1_INIT : seed1_reg;
    assign seed2_cur  = s1_start_reg ? SEED2_INIT : seed2_reg;
    assign table_word = s1_in_range_reg ? rd_data_reg : '0;

    always_comb
    begin
        seed1_next = seed1_reg;
        seed2_next = seed2_reg;
        if (s1_fire)
        begin
            seed1_next = table_word ^ (seed1_cur + seed2_cur);
            seed2_next = HASH_W'(s1_char_reg) + seed1_next + seed2_cur
                         + (seed2_cur << 5) + HASH_W'(SEED2_ADD);
        end
    end

    // Stage and output valid flags.
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (hash_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            seed1_reg     <= SEED1_INIT;
            seed2_reg     <= SEED2_INIT;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            seed1_reg     <= seed1_next;
            seed2_reg     <= seed2_next;
        end
    end

    // Payload registers of the second stage and the output.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_start_reg    <= key_in.key_start;
            s1_in_range_reg <= in_range;
            s1_char_reg     <= char_up;
        end
        if (s1_fire)
        begin
            out_hash_reg <= seed1_next;
        end
    end

    assign hash_out.valid      = out_valid_reg;
    assign hash_out.hash_value = out_hash_reg;

`ifndef SYNTH
    // No key word is taken before the seed table is complete.
    a_ready_after_fill: assert property (@(posedge clk) disable iff (!rst_n)
        key_in.ready |-> fill_done)
        else $error("key word accepted during table fill");
    // The table is never written while key words are hashed.
    a_no_write_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept || s1_valid_reg) |-> !wr_en)
        else $error("table write overlaps a lookup");
    // An accepted word reaches the second stage on the next cycle.
    a_accept_to_s1: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted word lost before second stage");
    // A finished word always lands in the output register.
    a_fire_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> (out_valid_reg && out_hash_reg == seed1_reg))
        else $error("result missing from output register");
`endif

endmodule

>>> design/table_keyed_string_hash.sv
// ----------------------------------------------------------------------------
// table_keyed_string_hash
// Streaming string hash with a generated seed table: one key byte in, the
// running hash out.
//
//   channel    dir  handshake      payload
//   key_in     in   valid / ready  key_start, table_row[2:0], key_byte[7:0]
//   hash_out   out  valid / ready  hash_value[31:0]
//
// After reset the seed table is generated, and key_in.ready stays low until
// then. After that one key word is taken every cycle while the second stage
// is free. A result passes through the registered table read, then through
// the seed update into the output register. A stalled output holds its word
// and the second stage behind it; the input keeps taking words while the
// second stage is free.
// ----------------------------------------------------------------------------
module table_keyed_string_hash import tksh_pkg::*;
#(
    parameter int TABLE_ROWS = 5
)
(
    input  logic        clk,
    input  logic        rst_n,
    tksh_in_if.sink     key_in,
    tksh_out_if.source  hash_out
);

    localparam int ADDR_W = $clog2(TABLE_ROWS*ROW_SIZE);

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [HASH_W-1:0] wr_data;
    logic              fill_done;

    // Seed table generator.
    tksh_fill #(
        .TABLE_ROWS (TABLE_ROWS)
    ) u_fill (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .done    (fill_done)
    );

    // Table memory and hash datapath.
    tksh_core #(
        .TABLE_ROWS (TABLE_ROWS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .fill_done (fill_done),
        .key_in    (key_in),
        .hash_out  (hash_out)
    );

endmodule

>>> test/tksh_hash_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tksh_hash_checker
// Watches the key and hash channels, predicts every running hash from its
// own seed table and seed registers, and compares each hash word in order.
// ----------------------------------------------------------------------------
module tksh_hash_checker import tksh_pkg::*;
#(
    parameter int TABLE_ROWS = 5
)
(
    input  logic clk,
    input  logic rst_n,
    tksh_in_if   key_in,
    tksh_out_if  hash_out,
    output int   fail_count,
    output int   pending_words,
    output int   hash_words_checked
);

    typedef struct packed {
        hash_t first;
        hash_t second;
    } seed_pair_t;

    localparam seed_pair_t SEEDS_AT_START = '{first: SEED1_INIT, second: SEED2_INIT};

    hash_t      seed_words [TABLE_ROWS * ROW_SIZE];
    seed_pair_t running_seeds;
    hash_t      expected_hashes [$];

    function automatic logic [31:0] lcg_advance(input logic [31:0] s);
        return (s * LCG_MUL + LCG_ADD) % LCG_MOD;
    endfunction

    // Fold one raw key byte into the seed pair.
    function automatic seed_pair_t fold_byte(input seed_pair_t cur,
                                             input logic [TABLE_ROW_W-1:0] row,
                                             input key_byte_t raw);
        key_byte_t  ch;
        hash_t      word;
        seed_pair_t nxt;
        ch = raw;
        if (raw >= CHAR_LOWER_A && raw <= CHAR_LOWER_Z)
        begin
            ch = raw - CASE_OFFSET;
        end
        // Rows past the end of the table contribute a zero word.
        word = '0;
        if (int'(row) < TABLE_ROWS)
        begin
            word = seed_words[int'(row) * ROW_SIZE + int'(ch)];
        end
        nxt.first  = word ^ (cur.first + cur.second);
        nxt.second = hash_t'(ch) + nxt.first + cur.second + (cur.second << 5)
                     + hash_t'(SEED2_ADD);
        return nxt;
    endfunction

    // Build the seed table column by column, two generator steps per word.
    initial
    begin : build_seed_table
        logic [31:0] lcg;
        hash_t       upper;
        lcg = 32'(LCG_START);
        for (int col = 0; col < ROW_SIZE; col++)
        begin
            for (int row = 0; row < TABLE_ROWS; row++)
            begin
                lcg   = lcg_advance(lcg);
                upper = hash_t'(lcg[LCG_HALF_W-1:0]) << LCG_HALF_W;
                lcg   = lcg_advance(lcg);
                seed_words[row * ROW_SIZE + col] = upper | hash_t'(lcg[LCG_HALF_W-1:0]);
            end
        end
    end

    // Track accepted key words and check hash words against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_seeds = SEEDS_AT_START;
            expected_hashes.delete();
            fail_count         <= 0;
            pending_words      <= 0;
            hash_words_checked <= 0;
        end
        else
        begin : track
            hash_t got;
            hash_t want;
            if (key_in.valid && key_in.ready)
            begin
                running_seeds = fold_byte(key_in.key_start ? SEEDS_AT_START : running_seeds,
                                          key_in.table_row, key_in.key_byte);
                expected_hashes.push_back(running_seeds.first);
            end
            if (hash_out.valid && hash_out.ready)
            begin
                got = hash_out.hash_value;
                if (expected_hashes.size() == 0)
                begin
                    $display("%0t: hash word with none expected, actual %08h", $time, got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_hashes.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: hash_value mismatch, expected %08h, actual %08h",
                                 $time, want, got);
                        fail_count <= fail_count + 1;
                    end
                end
                hash_words_checked <= hash_words_checked + 1;
            end
            pending_words <= expected_hashes.size();
        end
    end

endmodule

>>> test/table_keyed_string_hash_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// table_keyed_string_hash_test
// Drives key words into the string hash with random gaps and output stalls,
// one long output hold-off included, and lets the checker compare hashes.
// ----------------------------------------------------------------------------
module table_keyed_string_hash_test import tksh_pkg::*; ();

    localparam int TABLE_ROWS      = 5;
    localparam int TOTAL_WORDS     = 1700;
    localparam int CALM_WORDS      = 150;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int HOLD_OFF_AFTER  = 200;
    localparam int DRAIN_CYCLES    = 8;
    // The table fill after reset is the longest quiet stretch.
    localparam int WATCHDOG_LIMIT  = 82000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_words;
    int   hash_words_checked;
    int   words_sent;
    int   keys_started;
    int   far_row_words;
    int   idle_cycles;
    bit   calm_phase;

    tksh_in_if  key_in ();
    tksh_out_if hash_out ();

    table_keyed_string_hash #(.TABLE_ROWS(TABLE_ROWS)) u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .key_in   (key_in),
        .hash_out (hash_out)
    );

    tksh_hash_checker #(.TABLE_ROWS(TABLE_ROWS)) u_checker
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .key_in             (key_in),
        .hash_out           (hash_out),
        .fail_count         (fail_count),
        .pending_words      (pending_words),
        .hash_words_checked (hash_words_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Offer one key word, wait for it to be taken, then maybe pause.
    task automatic send_word(input bit start, input logic [TABLE_ROW_W-1:0] row,
                             input key_byte_t raw);
        key_in.valid     <= 1'b1;
        key_in.key_start <= start;
        key_in.table_row <= row;
        key_in.key_byte  <= raw;
        do
            @(posedge clk);
        while (!key_in.ready);
        words_sent++;
        if (start)
        begin
            keys_started++;
        end
        if (int'(row) >= TABLE_ROWS)
        begin
            far_row_words++;
        end
        if (words_sent >= TOTAL_WORDS - CALM_WORDS)
        begin
            calm_phase = 1'b1;
        end
        if (!calm_phase && $urandom_range(0, 7) == 0)
        begin
            key_in.valid     <= 1'b0;
            key_in.key_start <= 1'($urandom_range(0, 1));
            key_in.table_row <= TABLE_ROW_W'($urandom_range(0, 7));
            key_in.key_byte  <= key_byte_t'($urandom_range(0, 255));
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // One key: mostly well formed, sometimes with starts and rows scattered.
    task automatic send_key();
        int                     len;
        bit                     broken;
        logic [TABLE_ROW_W-1:0] row;
        key_byte_t              raw;
        len    = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
        broken = ($urandom_range(0, 7) == 0);
        row    = ($urandom_range(0, 9) == 0) ? TABLE_ROW_W'($urandom_range(TABLE_ROWS, 7))
                                             : TABLE_ROW_W'($urandom_range(0, TABLE_ROWS - 1));
        for (int i = 0; i < len; i++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: raw = key_byte_t'($urandom_range(CHAR_LOWER_A, CHAR_LOWER_Z));
                3, 4:    raw = key_byte_t'($urandom_range(CHAR_LOWER_A - CASE_OFFSET,
                                                          CHAR_LOWER_Z - CASE_OFFSET));
                5:
                begin
                    case ($urandom_range(0, 5))
                        0:       raw = CHAR_LOWER_A - 8'd1;
                        1:       raw = CHAR_LOWER_Z + 8'd1;
                        2:       raw = CHAR_LOWER_A - CASE_OFFSET - 8'd1;
                        3:       raw = CHAR_LOWER_Z - CASE_OFFSET + 8'd1;
                        4:       raw = 8'h00;
                        default: raw = 8'hFF;
                    endcase
                end
                default: raw = key_byte_t'($urandom_range(0, 255));
            endcase
            if (broken)
            begin
                send_word(1'($urandom_range(0, 1)), TABLE_ROW_W'($urandom_range(0, 7)), raw);
            end
            else
            begin
                send_word(i == 0, row, raw);
            end
        end
    endtask

    // Sender: reset, directed words, random keys, drain, verdict.
    initial
    begin
        key_in.valid     <= 1'b0;
        key_in.key_start <= 1'b0;
        key_in.table_row <= '0;
        key_in.key_byte  <= '0;
        words_sent    = 0;
        keys_started  = 0;
        far_row_words = 0;
        calm_phase    = 1'b0;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Bytes before any key start run on from the reset seeds.
        send_word(1'b0, 3'd0, CHAR_LOWER_A);
        send_word(1'b0, 3'd1, CHAR_LOWER_Z);
        // A zero byte is hashed like any other.
        send_word(1'b1, 3'd0, 8'h00);
        send_word(1'b0, 3'd4, 8'hFF);
        // Rows past the end of the table.
        send_word(1'b0, 3'd5, 8'h6D);
        send_word(1'b0, 3'd6, CHAR_LOWER_A - 8'd1);
        send_word(1'b0, 3'd7, CHAR_LOWER_Z + 8'd1);
        // Case folding edges: both cases of a letter must hash alike.
        send_word(1'b1, 3'd2, CHAR_LOWER_A - CASE_OFFSET);
        send_word(1'b0, 3'd2, CHAR_LOWER_Z - CASE_OFFSET);
        send_word(1'b0, 3'd3, CHAR_LOWER_A - CASE_OFFSET - 8'd1);
        send_word(1'b0, 3'd3, CHAR_LOWER_Z - CASE_OFFSET + 8'd1);
        send_word(1'b1, 3'd4, CHAR_LOWER_A);
        send_word(1'b1, 3'd4, CHAR_LOWER_A - CASE_OFFSET);
        send_word(1'b0, 3'd0, 8'h80);
        send_word(1'b0, 3'd1, 8'h7F);
        send_word(1'b1, 3'd7, 8'h00);

        while (words_sent < TOTAL_WORDS)
        begin
            send_key();
        end
        key_in.valid <= 1'b0;

        // Wait out the remaining hash words, then the pipeline latency.
        @(posedge clk);
        while (pending_words != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d key words in %0d keys, %0d on rows past the table; checked %0d hashes.",
                 words_sent, keys_started, far_row_words, hash_words_checked);
        $display("Output stalls included one hold-off of %0d cycles.", HOLD_OFF_CYCLES);
        if (pending_words != 0)
        begin
            $display("%0t: %0d hash words never arrived", $time, pending_words);
        end
        if (fail_count == 0 && pending_words == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Receiver: random stall bursts, and one long hold-off so the input backs up.
    initial
    begin : receiver
        bit held_off;
        held_off = 1'b0;
        hash_out.ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (!held_off && hash_words_checked >= HOLD_OFF_AFTER)
            begin
                held_off = 1'b1;
                hash_out.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hash_out.ready <= 1'b1;
            end
            else if (!calm_phase && $urandom_range(0, 9) == 0)
            begin
                hash_out.ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                hash_out.ready <= 1'b1;
            end
            else
            begin
                hash_out.ready <= 1'b1;
            end
        end
    end

    // Watchdog: too long without a word moving on either channel.
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((key_in.valid && key_in.ready) || (hash_out.valid && hash_out.ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
